>>> design/wgm_pkg.sv
`timescale 1ns / 1ps

package wgm_pkg;

  localparam int REG_BYTES = 32;

  localparam logic [7:0] STAR_CODE  = 8'h2A;
  localparam logic [7:0] QMARK_CODE = 8'h3F;

  typedef enum logic [2:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4,
    REG_FOLD = 3'd5
  } reg_index_t;

  // latin-1 lowercase
  function automatic logic [7:0] fold_latin1(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> design/wgm_match_vec.sv
`timescale 1ns / 1ps

module wgm_match_vec
  import wgm_pkg::*;
#(
  parameter int PB = 32
) (
  input  logic [7:0]      text_byte,
  input  logic [8*PB-1:0] pattern,
  input  logic            case_fold,
  output logic [PB-1:0]   match
);

  logic [7:0] text_folded;
  logic [7:0] pat_byte;

  always_comb begin
    text_folded = fold_latin1(text_byte);
    pat_byte = '0;
    for (int i = 0; i < PB; i++) begin
      pat_byte = pattern[8*i +: 8];
      match[i] = (pat_byte == QMARK_CODE) || (pat_byte == text_byte) ||
                 (case_fold && (fold_latin1(pat_byte) == text_folded));
    end
  end

endmodule

>>> design/wgm_star_close.sv
`timescale 1ns / 1ps

module wgm_star_close #(
  parameter int N = 33
) (
  input  logic [N-1:0] set_in,
  input  logic [N-2:0] link,
  output logic [N-1:0] set_out
);

  localparam int LV = $clog2(N);

  logic [N-1:0] g [LV+1];
  logic [N-1:0] p [LV+1];

  // prefix scan: position k+1 is reached from k when link[k]
  always_comb begin
    g[0] = set_in;
    p[0] = {link, 1'b0};
    for (int lv = 0; lv < LV; lv++) begin
      for (int k = 0; k < N; k++) begin
        if (k >= (1 << lv)) begin
          g[lv+1][k] = g[lv][k] | (p[lv][k] & g[lv][k - (1 << lv)]);
          p[lv+1][k] = p[lv][k] & p[lv][k - (1 << lv)];
        end else begin
          g[lv+1][k] = g[lv][k];
          p[lv+1][k] = p[lv][k];
        end
      end
    end
    set_out = g[LV];
  end

endmodule

>>> design/wildcard_glob_matcher.sv
`timescale 1ns / 1ps

// glob matcher: '*' any run, '?' one byte, else literal or latin-1 case-folded
// text channel: text_valid/text_ready carry text_byte and text_last, one word
//   per byte of a string; text_last marks the final byte of the string
// result channel: result_valid/result_ready carry one word per text byte:
//   matches_so_far, no_match_possible and string_done (echo of text_last)
// result path: the accepted byte passes the input stage register, then the result register
// throughput: one byte per cycle unless the receiver stalls; the byte compare is done
//   ahead of the input register, then the position set is updated by one combinational
//   pass (star scan, step, star scan) per byte
// configuration: apb port, 64-bit data, register i at byte address 8*i;
//   write only while no string is in flight
// reset: pattern, length and fold cleared; position set holds position 0
// after a last byte the position set restarts from position 0 with star closure
// receiver stall: the result word holds, one more byte is taken into the input stage if
//   it is empty, then text_ready drops until the result is taken
module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        text_last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        matches_so_far,
  output logic        no_match_possible,
  output logic        string_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int PB   = (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES : REG_BYTES;
  localparam int NPOS = PB + 1;
  localparam int NW   = $clog2(PB + 1);

  logic [7:0]          pat [PB];
  logic [5:0]          pattern_length;
  logic                case_fold;
  logic [8*PB-1:0]     pat_vec;
  logic [8*REG_BYTES-1:0] pat_flat;
  reg_index_t          cfg_index;
  logic                cfg_write;
  logic [NW-1:0]       n_eff;
  logic [NPOS-1:0]     len_mask;
  logic [NPOS-1:0]     end_hot;
  logic [PB-1:0]       star;

  logic [PB-1:0]       match_in;
  logic                s1_valid;
  logic [PB-1:0]       s1_match;
  logic                s1_last;
  logic                s1_adv;

  logic [NPOS-1:0]     active;
  logic [NPOS-1:0]     cur;
  logic [NPOS-1:0]     nx_pre;
  logic [NPOS-1:0]     nx;
  logic [NPOS-1:0]     start_set;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      case_fold <= 1'b0;
      for (int k = 0; k < PB; k++) begin
        pat[k] <= '0;
      end
    end else if (cfg_write) begin
      for (int k = 0; k < PB; k++) begin
        if (paddr[5:3] == 3'(k / 8)) begin
          pat[k] <= pwdata[8*(k % 8) +: 8];
        end
      end
      unique case (cfg_index)
        REG_LEN:  pattern_length <= pwdata[5:0];
        REG_FOLD: case_fold <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pat_flat = '0;
    for (int k = 0; k < PB; k++) begin
      pat_flat[8*k +: 8] = pat[k];
      pat_vec[8*k +: 8] = pat[k];
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_PAT0: prdata = pat_flat[63:0];
      REG_PAT1: prdata = pat_flat[127:64];
      REG_PAT2: prdata = pat_flat[191:128];
      REG_PAT3: prdata = pat_flat[255:192];
      REG_LEN:  prdata = {58'd0, pattern_length};
      REG_FOLD: prdata = {63'd0, case_fold};
      default:  prdata = '0;
    endcase
  end

  // pattern geometry
  assign n_eff = (pattern_length > 6'(PB)) ? NW'(PB) : pattern_length[NW-1:0];

  always_comb begin
    for (int k = 0; k < NPOS; k++) begin
      len_mask[k] = (NW'(k) <= n_eff);
      end_hot[k]  = (NW'(k) == n_eff);
    end
    for (int k = 0; k < PB; k++) begin
      star[k] = (pat[k] == STAR_CODE) && (NW'(k) < n_eff);
    end
  end

  // input stage: per-position byte compare
  wgm_match_vec #(.PB(PB)) u_match (
    .text_byte (text_byte),
    .pattern   (pat_vec),
    .case_fold (case_fold),
    .match     (match_in)
  );

  assign s1_adv     = !result_valid || result_ready;
  assign text_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_ready) begin
      s1_valid <= text_valid;
    end
    if (text_valid && text_ready) begin
      s1_match <= match_in;
      s1_last  <= text_last;
    end
  end

  // position update
  wgm_star_close #(.N(NPOS)) u_close_cur (
    .set_in  (active & len_mask),
    .link    (star),
    .set_out (cur)
  );

  always_comb begin
    nx_pre = '0;
    for (int i = 0; i < PB; i++) begin
      if (cur[i] && star[i]) begin
        nx_pre[i] = 1'b1;
      end
      if (cur[i] && !star[i] && s1_match[i] && (NW'(i) < n_eff)) begin
        nx_pre[i+1] = 1'b1;
      end
    end
  end

  wgm_star_close #(.N(NPOS)) u_close_nx (
    .set_in  (nx_pre),
    .link    (star),
    .set_out (nx)
  );

  wgm_star_close #(.N(NPOS)) u_close_start (
    .set_in  (NPOS'(1)),
    .link    (star),
    .set_out (start_set)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      active <= NPOS'(1);
    end else if (s1_adv) begin
      result_valid <= s1_valid;
      if (s1_valid) begin
        active <= s1_last ? start_set : nx;
      end
    end
    if (s1_adv && s1_valid) begin
      matches_so_far    <= |(nx & end_hot);
      no_match_possible <= ~|nx;
      string_done       <= s1_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(matches_so_far && no_match_possible))
    else $error("match and no-match reported together");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> text_ready)
    else $error("text stalled with empty result stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result_ready) |=> result_valid)
    else $error("input stage word lost");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && s1_last) |=> active[0])
    else $error("position set not restarted after last byte");
`endif

endmodule
